>>> hdl/srfr_pkg.sv
// Package for the sync and length framed byte receiver.
// Holds widths, reset values, code enums, shared structs and the CRC-16 byte update.
// No dependencies.
`default_nettype none
package srfr_pkg;

  localparam int MAX_FRAME = 512;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam int POS_OUT_W = 9;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 10;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CRC_W     = 16;
  localparam int TOT_W     = 17;

  localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
  localparam logic [TOT_W-1:0]  HDR_TRL_BYTES = 17'd6;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd93;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd71;
  localparam logic [BYTE_W-1:0] END_MARKER_RST  = 8'd3;
  localparam logic [LEN_W-1:0]  MIN_LEN_RST     = 10'd15;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST     = 10'd332;

  typedef enum logic [1:0] {
    PH_SYNC1 = 2'd0,
    PH_SYNC2 = 2'd1,
    PH_BODY  = 2'd2
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE       = 3'd0,
    ST_GOOD       = 3'd1,
    ST_CRC_BAD    = 3'd2,
    ST_MARKER_BAD = 3'd3,
    ST_LEN_BAD    = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_FIRST  = 3'd0,
    CFG_SYNC_SECOND = 3'd1,
    CFG_END_MARKER  = 3'd2,
    CFG_MIN_LEN     = 3'd3,
    CFG_MAX_LEN     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_first;
    logic [BYTE_W-1:0] sync_second;
    logic [BYTE_W-1:0] end_marker;
    logic [LEN_W-1:0]  min_len;
    logic [LEN_W-1:0]  max_len;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    data_byte;
    logic [POS_OUT_W-1:0] byte_position;
    logic                 in_frame;
    logic                 is_payload;
    logic                 frame_end;
    status_t              frame_status;
  } result_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hdl/srfr_cfg_regs.sv
// Configuration registers of the framed byte receiver: sync bytes, end marker, length limits.
// Depends on srfr_pkg.
`default_nettype none
module srfr_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [srfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [srfr_pkg::LEN_W-1:0]     cfg_data,
  output srfr_pkg::cfg_t                      cfg
);
  import srfr_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= SYNC_FIRST_RST;
      cfg_r.sync_second <= SYNC_SECOND_RST;
      cfg_r.end_marker  <= END_MARKER_RST;
      cfg_r.min_len     <= MIN_LEN_RST;
      cfg_r.max_len     <= MAX_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SYNC_FIRST:  cfg_r.sync_first  <= cfg_data[BYTE_W-1:0];
        CFG_SYNC_SECOND: cfg_r.sync_second <= cfg_data[BYTE_W-1:0];
        CFG_END_MARKER:  cfg_r.end_marker  <= cfg_data[BYTE_W-1:0];
        CFG_MIN_LEN:     cfg_r.min_len     <= cfg_data;
        CFG_MAX_LEN:     cfg_r.max_len     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/srfr_deframer.sv
// Frame state of the receiver and the single-pass logic that handles one byte.
// Depends on srfr_pkg for the CRC update, codes and structs.
`default_nettype none
module srfr_deframer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [srfr_pkg::BYTE_W-1:0] rx_byte,
  input  wire srfr_pkg::cfg_t              cfg,
  output srfr_pkg::result_t                res
);
  import srfr_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [BYTE_W-1:0]  len_hi_r, len_hi_nxt;
  logic [CRC_W-1:0]   crc_r, crc_nxt;
  logic [BYTE_W-1:0]  rx_crc_hi_r, rx_crc_hi_nxt;
  logic               marker_ok_r, marker_ok_nxt;

  logic [CRC_W-1:0]   crc_upd;
  logic [CRC_W-1:0]   len_full;
  logic [TOT_W-1:0]   total_calc;
  logic [CRC_W-1:0]   rx_crc;
  logic               len_bad;

  assign crc_upd    = crc_byte(crc_r, rx_byte);
  assign len_full   = {len_hi_r, rx_byte};
  assign total_calc = TOT_W'(len_full) + HDR_TRL_BYTES;
  assign rx_crc     = {rx_crc_hi_r, rx_byte};
  assign len_bad    = (total_calc < TOT_W'(cfg.min_len)) || (total_calc > TOT_W'(cfg.max_len))
                   || (total_calc > TOT_W'(MAX_FRAME));

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    total_nxt     = total_r;
    len_hi_nxt    = len_hi_r;
    crc_nxt       = crc_r;
    rx_crc_hi_nxt = rx_crc_hi_r;
    marker_ok_nxt = marker_ok_r;

    res.data_byte     = rx_byte;
    res.byte_position = '0;
    res.in_frame      = 1'b0;
    res.is_payload    = 1'b0;
    res.frame_end     = 1'b0;
    res.frame_status  = ST_NONE;

    case (phase_r)
      PH_BODY: begin
        res.in_frame      = 1'b1;
        res.byte_position = POS_OUT_W'(pos_r);
        if (pos_r == CNT_W'(2)) begin
          len_hi_nxt = rx_byte;
          crc_nxt    = crc_upd;
          pos_nxt    = CNT_W'(3);
        end else if (pos_r == CNT_W'(3)) begin
          crc_nxt = crc_upd;
          if (len_bad) begin
            res.frame_end    = 1'b1;
            res.frame_status = ST_LEN_BAD;
            phase_nxt        = PH_SYNC1;
            pos_nxt          = '0;
            total_nxt        = '0;
            len_hi_nxt       = '0;
            crc_nxt          = CRC_INIT;
            rx_crc_hi_nxt    = '0;
            marker_ok_nxt    = 1'b0;
          end else begin
            total_nxt = CNT_W'(total_calc);
            if (len_full == '0) begin
              marker_ok_nxt = (rx_byte == cfg.end_marker);
            end
            pos_nxt = CNT_W'(4);
          end
        end else if (pos_r <= total_r - CNT_W'(3)) begin
          res.is_payload = 1'b1;
          crc_nxt        = crc_upd;
          if (pos_r == total_r - CNT_W'(3)) begin
            marker_ok_nxt = (rx_byte == cfg.end_marker);
          end
          pos_nxt = pos_r + CNT_W'(1);
        end else if (pos_r == total_r - CNT_W'(2)) begin
          rx_crc_hi_nxt = rx_byte;
          pos_nxt       = pos_r + CNT_W'(1);
        end else begin
          res.frame_end = 1'b1;
          if (!marker_ok_r) begin
            res.frame_status = ST_MARKER_BAD;
          end else if (rx_crc != crc_r) begin
            res.frame_status = ST_CRC_BAD;
          end else begin
            res.frame_status = ST_GOOD;
          end
          phase_nxt     = PH_SYNC1;
          pos_nxt       = '0;
          total_nxt     = '0;
          len_hi_nxt    = '0;
          crc_nxt       = CRC_INIT;
          rx_crc_hi_nxt = '0;
          marker_ok_nxt = 1'b0;
        end
      end
      PH_SYNC2: begin
        if (rx_byte == cfg.sync_second) begin
          res.in_frame      = 1'b1;
          res.byte_position = POS_OUT_W'(1);
          phase_nxt         = PH_BODY;
          pos_nxt           = CNT_W'(2);
          crc_nxt           = CRC_INIT;
          marker_ok_nxt     = 1'b0;
        end else if (rx_byte == cfg.sync_first) begin
          res.in_frame = 1'b1;
          pos_nxt      = CNT_W'(1);
        end else begin
          phase_nxt     = PH_SYNC1;
          pos_nxt       = '0;
          total_nxt     = '0;
          len_hi_nxt    = '0;
          crc_nxt       = CRC_INIT;
          rx_crc_hi_nxt = '0;
          marker_ok_nxt = 1'b0;
        end
      end
      default: begin
        if (rx_byte == cfg.sync_first) begin
          res.in_frame = 1'b1;
          phase_nxt    = PH_SYNC2;
          pos_nxt      = CNT_W'(1);
        end else begin
          phase_nxt     = PH_SYNC1;
          pos_nxt       = '0;
          total_nxt     = '0;
          len_hi_nxt    = '0;
          crc_nxt       = CRC_INIT;
          rx_crc_hi_nxt = '0;
          marker_ok_nxt = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC1;
      pos_r       <= '0;
      total_r     <= '0;
      len_hi_r    <= '0;
      crc_r       <= CRC_INIT;
      rx_crc_hi_r <= '0;
      marker_ok_r <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      total_r     <= total_nxt;
      len_hi_r    <= len_hi_nxt;
      crc_r       <= crc_nxt;
      rx_crc_hi_r <= rx_crc_hi_nxt;
      marker_ok_r <= marker_ok_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/sync_length_crc16_frame_receiver.sv
// Sync and length framed byte receiver with CRC-16 Modbus check: one result per input byte.
// Accepts one byte per clock cycle unless a pending result is held by out_ready; each byte
// passes through the input register and then the result register. The rate is set by the
// single CRC-16 byte update and frame state logic that sits between the two. Configuration
// writes are taken on any cycle and must only be issued while no byte is in flight.
// Depends on srfr_pkg, srfr_cfg_regs and srfr_deframer.
`default_nettype none
module sync_length_crc16_frame_receiver (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [srfr_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [srfr_pkg::BYTE_W-1:0]         out_data_byte,
  output logic [srfr_pkg::POS_OUT_W-1:0]      out_byte_position,
  output logic                                out_in_frame,
  output logic                                out_is_payload,
  output logic                                out_frame_end,
  output logic [srfr_pkg::STATUS_W-1:0]       out_frame_status,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [srfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [srfr_pkg::LEN_W-1:0]     cfg_data
);
  import srfr_pkg::*;

  cfg_t              cfg;
  result_t           res;
  result_t           out_res_r;
  logic              out_valid_r;
  logic              s0_valid_r;
  logic [BYTE_W-1:0] s0_byte_r;
  logic              advance;
  logic              step;

  assign advance  = !out_valid_r || out_ready;
  assign step     = s0_valid_r && advance;
  assign in_ready = !s0_valid_r || advance;

  srfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srfr_deframer u_deframer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (s0_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s0_valid_r <= 1'b1;
    end else if (step) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data_byte     = out_res_r.data_byte;
  assign out_byte_position = out_res_r.byte_position;
  assign out_in_frame      = out_res_r.in_frame;
  assign out_is_payload    = out_res_r.is_payload;
  assign out_frame_end     = out_res_r.frame_end;
  assign out_frame_status  = out_res_r.frame_status;

endmodule
`default_nettype wire
